### src/gws_pkg.sv
// Shared constants, codes and controller/datapath interface types for the grid word search.
package gws_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int MAX_WORD = 64;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int GRID_AW = ROW_W + COL_W;
  localparam int WORD_AW = $clog2(MAX_WORD);
  localparam int LEN_W   = $clog2(MAX_WORD + 1);
  localparam int CHAR_W  = 8;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = CFG_W'(30);
  localparam logic [CFG_W-1:0] COL_COUNT_RST = CFG_W'(30);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  localparam logic REQ_GRID = 1'b0;
  localparam logic REQ_WORD = 1'b1;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_SCAN_INIT,
    DP_SCAN_NEXT,
    DP_DIR_INIT,
    DP_DIR_NEXT,
    DP_STEP,
    DP_ADV,
    DP_FOUND,
    DP_MISS,
    DP_LONG
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic empty;
    logic match;
    logic word_done;
    logic in_bounds;
    logic dir_last;
    logic scan_last;
  } sts_t;

endpackage

### src/gws_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module gws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/gws_datapath.sv
// Datapath: config registers, grid and word stores, scan and walk counters, result registers.
module gws_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gws_pkg::cmd_t                    cmd_i,
  output gws_pkg::sts_t                    sts_o,
  input  logic                             cfg_valid_i,
  input  logic [gws_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gws_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             req_type_i,
  input  logic [gws_pkg::ROW_W-1:0]        cell_row_i,
  input  logic [gws_pkg::COL_W-1:0]        cell_col_i,
  input  logic [gws_pkg::CHAR_W-1:0]       char_code_i,
  output logic                             found_o,
  output logic [gws_pkg::ROW_W-1:0]        start_row_o,
  output logic [gws_pkg::COL_W-1:0]        start_col_o,
  output logic [gws_pkg::ROW_W-1:0]        end_row_o,
  output logic [gws_pkg::COL_W-1:0]        end_col_o,
  output logic                             word_too_long_o
);

  typedef enum logic [1:0] {
    DIR_DOWN,
    DIR_UP,
    DIR_LEFT,
    DIR_RIGHT
  } dir_e;

  logic [gws_pkg::CFG_W-1:0]  row_cnt_q, col_cnt_q;
  logic [gws_pkg::CFG_W-1:0]  rows_eff, cols_eff;
  logic [gws_pkg::LEN_W-1:0]  word_len_q;
  logic                       word_ovf_q;
  logic [gws_pkg::ROW_W-1:0]  scan_r_q, pos_r_q, nscan_r;
  logic [gws_pkg::COL_W-1:0]  scan_c_q, pos_c_q, nscan_c;
  logic [gws_pkg::CFG_W-1:0]  scan_r_inc, scan_c_inc, pos_r_inc, pos_c_inc;
  dir_e                       dir_q;
  logic [1:0]                 dir_inc;
  logic [gws_pkg::LEN_W-1:0]  idx_q;
  logic                       found_q, long_q;
  logic [gws_pkg::ROW_W-1:0]  start_r_q, end_r_q;
  logic [gws_pkg::COL_W-1:0]  start_c_q, end_c_q;
  logic [gws_pkg::CHAR_W-1:0] grid_rd, word_rd;
  logic                       word_full, grid_we, word_we, word_clr;

  assign rows_eff = (row_cnt_q > gws_pkg::CFG_W'(gws_pkg::MAX_ROWS)) ?
                    gws_pkg::CFG_W'(gws_pkg::MAX_ROWS) : row_cnt_q;
  assign cols_eff = (col_cnt_q > gws_pkg::CFG_W'(gws_pkg::MAX_COLS)) ?
                    gws_pkg::CFG_W'(gws_pkg::MAX_COLS) : col_cnt_q;

  assign scan_r_inc = gws_pkg::CFG_W'(scan_r_q) + gws_pkg::CFG_W'(1);
  assign scan_c_inc = gws_pkg::CFG_W'(scan_c_q) + gws_pkg::CFG_W'(1);
  assign pos_r_inc  = gws_pkg::CFG_W'(pos_r_q) + gws_pkg::CFG_W'(1);
  assign pos_c_inc  = gws_pkg::CFG_W'(pos_c_q) + gws_pkg::CFG_W'(1);
  assign dir_inc    = dir_q + 2'd1;

  // row-major scan advance
  always_comb begin
    if (scan_c_inc >= cols_eff) begin
      nscan_c = '0;
      nscan_r = scan_r_inc[gws_pkg::ROW_W-1:0];
    end else begin
      nscan_c = scan_c_inc[gws_pkg::COL_W-1:0];
      nscan_r = scan_r_q;
    end
  end

  assign word_full = (word_len_q == gws_pkg::LEN_W'(gws_pkg::MAX_WORD));
  assign grid_we   = cmd_i.accept && (req_type_i == gws_pkg::REQ_GRID);
  assign word_we   = cmd_i.accept && (req_type_i == gws_pkg::REQ_WORD) && !word_full;
  assign word_clr  = (cmd_i.op == gws_pkg::DP_FOUND) || (cmd_i.op == gws_pkg::DP_MISS) ||
                     (cmd_i.op == gws_pkg::DP_LONG);

  gws_ram #(
    .WIDTH (gws_pkg::CHAR_W),
    .DEPTH (1 << gws_pkg::GRID_AW)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i ({cell_row_i, cell_col_i}),
    .wdata_i (char_code_i),
    .raddr_i ({pos_r_q, pos_c_q}),
    .rdata_o (grid_rd)
  );

  gws_ram #(
    .WIDTH (gws_pkg::CHAR_W),
    .DEPTH (1 << gws_pkg::WORD_AW)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (word_len_q[gws_pkg::WORD_AW-1:0]),
    .wdata_i (char_code_i),
    .raddr_i (idx_q[gws_pkg::WORD_AW-1:0]),
    .rdata_o (word_rd)
  );

  always_comb begin
    sts_o.ovf       = word_ovf_q || word_full;
    sts_o.empty     = (row_cnt_q == '0) || (col_cnt_q == '0);
    sts_o.match     = (grid_rd == word_rd);
    sts_o.word_done = (idx_q == word_len_q);
    sts_o.dir_last  = (dir_q == DIR_RIGHT);
    sts_o.scan_last = (scan_c_inc >= cols_eff) && (scan_r_inc >= rows_eff);
    case (dir_q)
      DIR_DOWN:  sts_o.in_bounds = pos_r_inc < rows_eff;
      DIR_UP:    sts_o.in_bounds = pos_r_q != '0;
      DIR_LEFT:  sts_o.in_bounds = pos_c_q != '0;
      DIR_RIGHT: sts_o.in_bounds = pos_c_inc < cols_eff;
      default:   sts_o.in_bounds = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q  <= gws_pkg::ROW_COUNT_RST;
      col_cnt_q  <= gws_pkg::COL_COUNT_RST;
      word_len_q <= '0;
      word_ovf_q <= 1'b0;
      scan_r_q   <= '0;
      scan_c_q   <= '0;
      pos_r_q    <= '0;
      pos_c_q    <= '0;
      dir_q      <= DIR_DOWN;
      idx_q      <= '0;
      found_q    <= 1'b0;
      long_q     <= 1'b0;
      start_r_q  <= '0;
      start_c_q  <= '0;
      end_r_q    <= '0;
      end_c_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == gws_pkg::REG_ROW_COUNT) begin
          row_cnt_q <= cfg_data_i;
        end else if (cfg_index_i == gws_pkg::REG_COL_COUNT) begin
          col_cnt_q <= cfg_data_i;
        end
      end

      if (word_clr) begin
        word_len_q <= '0;
        word_ovf_q <= 1'b0;
      end else if (cmd_i.accept && (req_type_i == gws_pkg::REQ_WORD)) begin
        if (word_full) begin
          word_ovf_q <= 1'b1;
        end else begin
          word_len_q <= word_len_q + gws_pkg::LEN_W'(1);
        end
      end

      case (cmd_i.op)
        gws_pkg::DP_SCAN_INIT: begin
          scan_r_q <= '0;
          scan_c_q <= '0;
          pos_r_q  <= '0;
          pos_c_q  <= '0;
          idx_q    <= '0;
        end
        gws_pkg::DP_SCAN_NEXT: begin
          scan_r_q <= nscan_r;
          scan_c_q <= nscan_c;
          pos_r_q  <= nscan_r;
          pos_c_q  <= nscan_c;
          idx_q    <= '0;
        end
        gws_pkg::DP_DIR_INIT: begin
          dir_q   <= DIR_DOWN;
          pos_r_q <= scan_r_q;
          pos_c_q <= scan_c_q;
          idx_q   <= gws_pkg::LEN_W'(1);
        end
        gws_pkg::DP_DIR_NEXT: begin
          dir_q   <= dir_e'(dir_inc);
          pos_r_q <= scan_r_q;
          pos_c_q <= scan_c_q;
          idx_q   <= gws_pkg::LEN_W'(1);
        end
        gws_pkg::DP_STEP: begin
          case (dir_q)
            DIR_DOWN:  pos_r_q <= pos_r_inc[gws_pkg::ROW_W-1:0];
            DIR_UP:    pos_r_q <= pos_r_q - gws_pkg::ROW_W'(1);
            DIR_LEFT:  pos_c_q <= pos_c_q - gws_pkg::COL_W'(1);
            DIR_RIGHT: pos_c_q <= pos_c_inc[gws_pkg::COL_W-1:0];
            default:   pos_r_q <= pos_r_q;
          endcase
        end
        gws_pkg::DP_ADV: begin
          idx_q <= idx_q + gws_pkg::LEN_W'(1);
        end
        gws_pkg::DP_FOUND: begin
          found_q   <= 1'b1;
          long_q    <= 1'b0;
          start_r_q <= scan_r_q;
          start_c_q <= scan_c_q;
          end_r_q   <= pos_r_q;
          end_c_q   <= pos_c_q;
        end
        gws_pkg::DP_MISS, gws_pkg::DP_LONG: begin
          found_q   <= 1'b0;
          long_q    <= (cmd_i.op == gws_pkg::DP_LONG);
          start_r_q <= '0;
          start_c_q <= '0;
          end_r_q   <= '0;
          end_c_q   <= '0;
        end
        default: begin
          idx_q <= idx_q;
        end
      endcase
    end
  end

  assign found_o         = found_q;
  assign word_too_long_o = long_q;
  assign start_row_o     = start_r_q;
  assign start_col_o     = start_c_q;
  assign end_row_o       = end_r_q;
  assign end_col_o       = end_c_q;

endmodule

### src/gws_ctrl.sv
// Controller: search sequencer driving the datapath, plus busy flag and done strobe.
module gws_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          req_type_i,
  input  logic          word_last_i,
  input  gws_pkg::sts_t sts_i,
  output gws_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL_WAIT,
    S_CELL_CMP,
    S_DIR_CHK,
    S_STEP_WAIT,
    S_STEP_CMP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;
  logic   dir_fail;

  always_comb begin
    cmd_o.accept = 1'b0;
    cmd_o.op     = gws_pkg::DP_NOP;
    state_d      = state_q;
    busy_d       = busy_q;
    done_d       = 1'b0;
    dir_fail     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if ((req_type_i == gws_pkg::REQ_WORD) && word_last_i) begin
            if (sts_i.ovf) begin
              cmd_o.op = gws_pkg::DP_LONG;
              done_d   = 1'b1;
            end else if (sts_i.empty) begin
              cmd_o.op = gws_pkg::DP_MISS;
              done_d   = 1'b1;
            end else begin
              cmd_o.op = gws_pkg::DP_SCAN_INIT;
              busy_d   = 1'b1;
              state_d  = S_CELL_WAIT;
            end
          end
        end
      end
      S_CELL_WAIT: begin
        state_d = S_CELL_CMP;
      end
      S_CELL_CMP: begin
        if (sts_i.match) begin
          cmd_o.op = gws_pkg::DP_DIR_INIT;
          state_d  = S_DIR_CHK;
        end else begin
          dir_fail = 1'b1;
        end
      end
      S_DIR_CHK: begin
        if (sts_i.word_done) begin
          cmd_o.op = gws_pkg::DP_FOUND;
          done_d   = 1'b1;
          busy_d   = 1'b0;
          state_d  = S_IDLE;
        end else if (sts_i.in_bounds) begin
          cmd_o.op = gws_pkg::DP_STEP;
          state_d  = S_STEP_WAIT;
        end else begin
          dir_fail = 1'b1;
        end
      end
      S_STEP_WAIT: begin
        state_d = S_STEP_CMP;
      end
      S_STEP_CMP: begin
        if (sts_i.match) begin
          cmd_o.op = gws_pkg::DP_ADV;
          state_d  = S_DIR_CHK;
        end else begin
          dir_fail = 1'b1;
        end
      end
      default: begin
        busy_d  = 1'b0;
        state_d = S_IDLE;
      end
    endcase

    // cell mismatch counts as a failed last direction
    if (dir_fail) begin
      if (!sts_i.dir_last && (state_q != S_CELL_CMP)) begin
        cmd_o.op = gws_pkg::DP_DIR_NEXT;
        state_d  = S_DIR_CHK;
      end else if (sts_i.scan_last) begin
        cmd_o.op = gws_pkg::DP_MISS;
        done_d   = 1'b1;
        busy_d   = 1'b0;
        state_d  = S_IDLE;
      end else begin
        cmd_o.op = gws_pkg::DP_SCAN_NEXT;
        state_d  = S_CELL_WAIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

### src/grid_word_search.sv
// Top level of the four-direction grid word search.
// Grid writes and non-final word beats leave busy_o low.
// Final word beat: done_o strobes the cycle after acceptance if the word overflowed or a count
// is zero; else the controller scans the cells in row-major order, tries each direction at a
// first-letter match, compares letter by letter with a grid RAM read each, and done_o follows.
// rst_ni clears counters and word length, sets config to 30 x 30; RAM contents are not cleared.
// Results cannot be stalled: each is on the ports from the done_o cycle until the next result.
module grid_word_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  output logic                          done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gws_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gws_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          req_type_i,
  input  logic [gws_pkg::ROW_W-1:0]     cell_row_i,
  input  logic [gws_pkg::COL_W-1:0]     cell_col_i,
  input  logic [gws_pkg::CHAR_W-1:0]    char_code_i,
  input  logic                          word_last_i,
  output logic                          found_o,
  output logic [gws_pkg::ROW_W-1:0]     start_row_o,
  output logic [gws_pkg::COL_W-1:0]     start_col_o,
  output logic [gws_pkg::ROW_W-1:0]     end_row_o,
  output logic [gws_pkg::COL_W-1:0]     end_col_o,
  output logic                          word_too_long_o
);

  gws_pkg::cmd_t cmd;
  gws_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  gws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_type_i  (req_type_i),
    .word_last_i (word_last_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  gws_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .cell_row_i      (cell_row_i),
    .cell_col_i      (cell_col_i),
    .char_code_i     (char_code_i),
    .found_o         (found_o),
    .start_row_o     (start_row_o),
    .start_col_o     (start_col_o),
    .end_row_o       (end_row_o),
    .end_col_o       (end_col_o),
    .word_too_long_o (word_too_long_o)
  );

endmodule

### src/gws_checker.sv
// Port-level checker for the grid word search, bound to the top level.
module gws_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic                          req_type_i,
  input logic                          found_o,
  input logic [gws_pkg::ROW_W-1:0]     start_row_o,
  input logic [gws_pkg::COL_W-1:0]     start_col_o,
  input logic [gws_pkg::ROW_W-1:0]     end_row_o,
  input logic [gws_pkg::COL_W-1:0]     end_col_o,
  input logic                          word_too_long_o
);

  // a search only ends with a result beat
  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result beat");

  // a miss reports all positions as zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |->
      (start_row_o == '0) && (start_col_o == '0) && (end_row_o == '0) && (end_col_o == '0))
    else $error("miss with nonzero positions");

  // overflowed word is never found
  a_long_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && word_too_long_o) |-> !found_o)
    else $error("overflowed word reported as found");

  // a match lies on one row or one column
  a_match_straight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (start_row_o == end_row_o) || (start_col_o == end_col_o))
    else $error("match not along a row or column");

  // a grid write beat never produces a result
  a_grid_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_type_i == gws_pkg::REQ_GRID)) |=> !done_o)
    else $error("result after grid write beat");

endmodule

bind grid_word_search gws_checker u_gws_checker (.*);

### dv/grid_word_search_tb.sv
// Self-checking testbench for grid_word_search: directed and random grid/word traffic.
`timescale 1ns / 100ps

module grid_word_search_tb;

  localparam int QUIET_LIMIT = 5000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DROW [4] = '{1, -1, 0, 0};
  localparam int DCOL [4] = '{0, 0, -1, 1};

  typedef struct packed {
    logic                      found;
    logic [gws_pkg::ROW_W-1:0] start_row;
    logic [gws_pkg::COL_W-1:0] start_col;
    logic [gws_pkg::ROW_W-1:0] end_row;
    logic [gws_pkg::COL_W-1:0] end_col;
    logic                      too_long;
  } hit_t;

  class word_hunt_sb;
    logic [gws_pkg::CHAR_W-1:0] grid [gws_pkg::MAX_ROWS][gws_pkg::MAX_COLS];
    bit                         seen [gws_pkg::MAX_ROWS][gws_pkg::MAX_COLS];
    logic [gws_pkg::CHAR_W-1:0] word [gws_pkg::MAX_WORD];
    int                         word_len;
    bit                         word_ovf;
    int                         rows_cfg;
    int                         cols_cfg;
    hit_t                       pending_hits[$];
    int                         fails;
    int                         hits_checked;

    function new();
      word_len = 0;
      word_ovf = 0;
      rows_cfg = gws_pkg::ROW_COUNT_RST;
      cols_cfg = gws_pkg::COL_COUNT_RST;
      fails = 0;
      hits_checked = 0;
    endfunction

    function int rows_used();
      return (rows_cfg > gws_pkg::MAX_ROWS) ? gws_pkg::MAX_ROWS : rows_cfg;
    endfunction

    function int cols_used();
      return (cols_cfg > gws_pkg::MAX_COLS) ? gws_pkg::MAX_COLS : cols_cfg;
    endfunction

    function void set_reg(logic [gws_pkg::CFG_IDX_W-1:0] idx, logic [gws_pkg::CFG_W-1:0] data);
      if (idx == gws_pkg::REG_ROW_COUNT) rows_cfg = data;
      else if (idx == gws_pkg::REG_COL_COUNT) cols_cfg = data;
    endfunction

    function bit follow(int r, int c, int k, int nr, int nc, output int er, output int ec);
      er = r;
      ec = c;
      for (int i = 1; i < word_len; i++) begin
        r += DROW[k];
        c += DCOL[k];
        if (r < 0 || r >= nr || c < 0 || c >= nc) return 0;
        if (grid[r][c] != word[i]) return 0;
      end
      er = r;
      ec = c;
      return 1;
    endfunction

    function hit_t locate();
      hit_t h;
      int nr, nc, er, ec;
      h = '0;
      nr = rows_used();
      nc = cols_used();
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          if (grid[r][c] != word[0]) continue;
          for (int k = 0; k < 4; k++) begin
            if (follow(r, c, k, nr, nc, er, ec)) begin
              h.found = 1'b1;
              h.start_row = gws_pkg::ROW_W'(r);
              h.start_col = gws_pkg::COL_W'(c);
              h.end_row = gws_pkg::ROW_W'(er);
              h.end_col = gws_pkg::COL_W'(ec);
              return h;
            end
          end
        end
      end
      return h;
    endfunction

    function void note_item(logic req, logic [gws_pkg::ROW_W-1:0] row,
                            logic [gws_pkg::COL_W-1:0] col,
                            logic [gws_pkg::CHAR_W-1:0] ch, logic last);
      hit_t h;
      if (req == gws_pkg::REQ_GRID) begin
        grid[row][col] = ch;
        seen[row][col] = 1'b1;
        return;
      end
      if (word_len < gws_pkg::MAX_WORD) begin
        word[word_len] = ch;
        word_len++;
      end else begin
        word_ovf = 1'b1;
      end
      if (!last) return;
      h = '0;
      if (word_ovf) h.too_long = 1'b1;
      else h = locate();
      pending_hits.push_back(h);
      word_len = 0;
      word_ovf = 0;
    endfunction

    task report(string what);
      $display("mismatch on result %0d: %s", hits_checked, what);
      fails++;
    endtask

    task check_hit(hit_t got);
      hit_t want;
      if (pending_hits.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = pending_hits.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %b, want %b", got.found, want.found));
      if (got.start_row !== want.start_row)
        report($sformatf("start_row %0d, want %0d", got.start_row, want.start_row));
      if (got.start_col !== want.start_col)
        report($sformatf("start_col %0d, want %0d", got.start_col, want.start_col));
      if (got.end_row !== want.end_row)
        report($sformatf("end_row %0d, want %0d", got.end_row, want.end_row));
      if (got.end_col !== want.end_col)
        report($sformatf("end_col %0d, want %0d", got.end_col, want.end_col));
      if (got.too_long !== want.too_long)
        report($sformatf("word_too_long %b, want %b", got.too_long, want.too_long));
      hits_checked++;
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic                          done_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [gws_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [gws_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          req_type_i = gws_pkg::REQ_GRID;
  logic [gws_pkg::ROW_W-1:0]     cell_row_i = '0;
  logic [gws_pkg::COL_W-1:0]     cell_col_i = '0;
  logic [gws_pkg::CHAR_W-1:0]    char_code_i = '0;
  logic                          word_last_i = 1'b0;
  logic                          found_o;
  logic [gws_pkg::ROW_W-1:0]     start_row_o;
  logic [gws_pkg::COL_W-1:0]     start_col_o;
  logic [gws_pkg::ROW_W-1:0]     end_row_o;
  logic [gws_pkg::COL_W-1:0]     end_col_o;
  logic                          word_too_long_o;

  hit_t        out_hit;
  word_hunt_sb sb = new();
  int          item_count = 0;
  int          quiet = 0;
  bit          steady = 0;

  assign out_hit = '{found_o, start_row_o, start_col_o, end_row_o, end_col_o, word_too_long_o};

  grid_word_search uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .cell_row_i      (cell_row_i),
    .cell_col_i      (cell_col_i),
    .char_code_i     (char_code_i),
    .word_last_i     (word_last_i),
    .found_o         (found_o),
    .start_row_o     (start_row_o),
    .start_col_o     (start_col_o),
    .end_row_o       (end_row_o),
    .end_col_o       (end_col_o),
    .word_too_long_o (word_too_long_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) sb.check_hit(out_hit);
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [gws_pkg::CHAR_W-1:0] pick_char();
    if ($urandom_range(9) == 0) return gws_pkg::CHAR_W'($urandom_range(255));
    return gws_pkg::CHAR_W'(8'h41 + $urandom_range(3));
  endfunction

  task automatic send_beat(logic req, logic [gws_pkg::ROW_W-1:0] row,
                           logic [gws_pkg::COL_W-1:0] col,
                           logic [gws_pkg::CHAR_W-1:0] ch, logic last);
    while (!steady && $urandom_range(99) < 35) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_type_i <= req;
    cell_row_i <= row;
    cell_col_i <= col;
    char_code_i <= ch;
    word_last_i <= last;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(req, row, col, ch, last);
    item_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_beat(gws_pkg::REQ_WORD, gws_pkg::ROW_W'($urandom_range(63)),
                gws_pkg::COL_W'($urandom_range(63)), s[i], i == s.len() - 1);
  endtask

  task automatic send_word(logic [gws_pkg::CHAR_W-1:0] q[$]);
    for (int i = 0; i < q.size(); i++)
      send_beat(gws_pkg::REQ_WORD, gws_pkg::ROW_W'($urandom_range(63)),
                gws_pkg::COL_W'($urandom_range(63)), q[i], i == q.size() - 1);
  endtask

  task automatic send_filler_word(int len);
    for (int i = 0; i < len; i++)
      send_beat(gws_pkg::REQ_WORD, gws_pkg::ROW_W'($urandom_range(63)),
                gws_pkg::COL_W'($urandom_range(63)),
                gws_pkg::CHAR_W'($urandom_range(255)), i == len - 1);
  endtask

  task automatic send_random_word();
    logic [gws_pkg::CHAR_W-1:0] q[$];
    int len;
    len = $urandom_range(1, 4);
    repeat (len) q.push_back(pick_char());
    send_word(q);
  endtask

  // walk a straight line through the current grid so most words can be found
  task automatic send_path_word();
    logic [gws_pkg::CHAR_W-1:0] q[$];
    int r, c, k, len, nr, nc;
    nr = sb.rows_used();
    nc = sb.cols_used();
    if (nr == 0 || nc == 0) begin
      send_random_word();
      return;
    end
    r = $urandom_range(nr - 1);
    c = $urandom_range(nc - 1);
    k = $urandom_range(3);
    len = $urandom_range(1, 8);
    q.push_back(sb.grid[r][c]);
    while (q.size() < len) begin
      r += DROW[k];
      c += DCOL[k];
      if (r < 0 || r >= nr || c < 0 || c >= nc) break;
      q.push_back(sb.grid[r][c]);
    end
    if ($urandom_range(4) == 0) q[q.size() - 1] = q[q.size() - 1] ^ 8'h01;
    send_word(q);
  endtask

  task automatic send_grid_write();
    int nr, nc;
    logic [gws_pkg::ROW_W-1:0] row;
    logic [gws_pkg::COL_W-1:0] col;
    nr = sb.rows_used();
    nc = sb.cols_used();
    if ($urandom_range(1) == 1 && nr > 0 && nc > 0) begin
      row = gws_pkg::ROW_W'($urandom_range(nr - 1));
      col = gws_pkg::COL_W'($urandom_range(nc - 1));
    end else begin
      row = gws_pkg::ROW_W'($urandom_range(63));
      col = gws_pkg::COL_W'($urandom_range(63));
    end
    send_beat(gws_pkg::REQ_GRID, row, col, pick_char(), 1'($urandom_range(1)));
  endtask

  // every cell a search can touch must hold a known byte
  task automatic fill_region();
    for (int r = 0; r < sb.rows_used(); r++) begin
      for (int c = 0; c < sb.cols_used(); c++) begin
        if (!sb.seen[r][c])
          send_beat(gws_pkg::REQ_GRID, gws_pkg::ROW_W'(r), gws_pkg::COL_W'(c), pick_char(),
                    1'($urandom_range(1)));
      end
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [gws_pkg::CFG_IDX_W-1:0] idx,
                           logic [gws_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_dims(int rows, int cols);
    if ($urandom_range(1) == 1) begin
      write_reg(gws_pkg::REG_ROW_COUNT, gws_pkg::CFG_W'(rows));
      write_reg(gws_pkg::REG_COL_COUNT, gws_pkg::CFG_W'(cols));
    end else begin
      write_reg(gws_pkg::REG_COL_COUNT, gws_pkg::CFG_W'(cols));
      write_reg(gws_pkg::REG_ROW_COUNT, gws_pkg::CFG_W'(rows));
    end
  endtask

  function automatic int pick_dim();
    case ($urandom_range(19))
      0: return 0;
      1: return 1;
      2: return $urandom_range(9, 30);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  initial begin
    logic [gws_pkg::CHAR_W-1:0] layout [12];
    int phase, n, sel;

    layout = '{"A", "B", "C", "D", "E", "F", "G", 8'h00, "H", "I", "J", 8'hFF};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: 3 x 4 grid, each direction, misses, odd bytes, overflow
    set_dims(3, 4);
    for (int i = 0; i < 12; i++)
      send_beat(gws_pkg::REQ_GRID, gws_pkg::ROW_W'(i / 4), gws_pkg::COL_W'(i % 4), layout[i],
                1'b0);
    send_text("F");
    send_text("BFI");
    send_text("JGC");
    send_text("GFE");
    send_text("ABCD");
    send_text("AZ");
    send_text("DE");
    send_beat(gws_pkg::REQ_WORD, 6'd0, 6'd0, 8'h00, 1'b0);
    send_beat(gws_pkg::REQ_WORD, 6'd63, 6'd63, 8'hFF, 1'b1);
    send_beat(gws_pkg::REQ_GRID, 6'd0, 6'd3, "D", 1'b1);
    send_text("CD");
    send_filler_word(gws_pkg::MAX_WORD + 2);
    send_text("A");
    send_filler_word(gws_pkg::MAX_WORD);
    settle();
    write_reg(gws_pkg::REG_ROW_COUNT, '0);
    send_text("A");
    settle();
    set_dims(3, 0);
    send_text("A");
    settle();

    phase = 0;
    while (item_count < 550 || phase < 6) begin
      settle();
      case (phase)
        0: set_dims(127, 1);
        1: set_dims(0, 5);
        3: set_dims(1, 127);
        4: set_dims(1, 64);
        5: set_dims(64, 1);
        default: set_dims(pick_dim(), pick_dim());
      endcase
      fill_region();
      steady = (phase == 2);
      if (steady) n = 20;
      else if (sb.rows_used() * sb.cols_used() > 256) n = 8;
      else n = $urandom_range(4, 12);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(99);
        if (sel < 30) send_grid_write();
        else if (sel < 88) send_path_word();
        else if (sel < 97) send_random_word();
        else if (sel < 99)
          send_filler_word($urandom_range(gws_pkg::MAX_WORD + 1, gws_pkg::MAX_WORD + 6));
        else send_filler_word(gws_pkg::MAX_WORD);
        if (i == n / 2 && phase % 2 == 1) settle();
      end
      steady = 0;
      phase++;
    end

    settle();
    if (sb.fails == 0 && sb.pending_hits.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### files.f
src/gws_pkg.sv
src/gws_ram.sv
src/gws_datapath.sv
src/gws_ctrl.sv
src/grid_word_search.sv
src/gws_checker.sv
dv/grid_word_search_tb.sv
